// File: src/lpd_pkg.sv
package lpd_pkg;

  localparam int unsigned SENSOR_BITS_DEF = 12;
  localparam int unsigned GAIN_FRAC_DEF   = 8;

  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned ELAPSED_W   = 8;
  localparam int unsigned SLOPE_FRAC  = 8;
  localparam int unsigned SLOPE_W     = 21;
  localparam int unsigned INTEG_W     = 32;
  localparam int unsigned DRIVE_W     = 8;
  localparam int unsigned DRIVE_LIMIT = 127;
  localparam int unsigned CFG_IDX_W   = 2;

  // full-precision drive sum: gain x (integral << slope frac), plus sign and carry
  localparam int unsigned ACC_W   = GAIN_W + INTEG_W + SLOPE_FRAC + 1;
  localparam int unsigned TERM_N  = 3;
  localparam int unsigned MAC_CYC = TERM_N * GAIN_W;
  localparam int unsigned CYC_W   = $clog2(MAC_CYC);
  localparam int unsigned GB_W    = $clog2(GAIN_W);
  localparam int unsigned TERM_W  = CYC_W - GB_W;

endpackage

// File: src/lift_pid_drive.sv
// An accepted input word runs the multiply in ST_RUN (skipped when target reached), then waits in ST_FIN
//   until the output register is free; no new input word is taken until its output word is loaded.
// Bit-serial gain multiply: one gain bit per cycle over three 16-bit gains.
// Integral multiply and slope divide (one quotient bit per cycle) run alongside.
// Reset (async, active low) clears gains, target, integral, last error and slope.
module lift_pid_drive #(
  parameter int unsigned SENSOR_BITS        = lpd_pkg::SENSOR_BITS_DEF,
  parameter int unsigned GAIN_FRACTION_BITS = lpd_pkg::GAIN_FRAC_DEF,
  localparam int unsigned S_DATA_W = ((SENSOR_BITS + lpd_pkg::ELAPSED_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpd_pkg::GAIN_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [S_DATA_W-1:0]           s_axis_tdata,  // position_sample, elapsed_ms
  input  logic [0:0]                    s_axis_tuser,  // start_run
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lpd_pkg::DRIVE_W-1:0]   m_axis_tdata,  // drive_value
  output logic [0:0]                    m_axis_tuser   // target_reached
);
  import lpd_pkg::*;

  localparam int unsigned ERR_W  = SENSOR_BITS + 1;
  localparam int unsigned PROD_W = SENSOR_BITS + ELAPSED_W;
  localparam int unsigned DVD_W  = SENSOR_BITS + SLOPE_FRAC;
  localparam int unsigned SHIFT  = GAIN_FRACTION_BITS + SLOPE_FRAC;
  localparam int unsigned QC_W   = (DVD_W > SLOPE_W) ? DVD_W : SLOPE_W;

  localparam logic [QC_W-1:0]    SLOPE_LIM = QC_W'(64'd1 << (SLOPE_W - 1));
  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam logic [TERM_W-1:0] TERM_P = TERM_W'(0);
  localparam logic [TERM_W-1:0] TERM_I = TERM_W'(1);
  localparam logic [TERM_W-1:0] TERM_D = TERM_W'(2);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_e;
  typedef enum logic [CFG_IDX_W-1:0] {REG_TARGET, REG_KP, REG_KI, REG_KD} cfg_reg_e;

  state_e                  state_q;
  logic [CYC_W-1:0]        cyc_q;
  logic [SENSOR_BITS-1:0]  target_q;
  logic [GAIN_W-1:0]       kp_q, ki_q, kd_q;
  logic [INTEG_W-1:0]      integ_q;
  logic [ERR_W-1:0]        last_err_q;
  logic [SLOPE_W-1:0]      slope_q;
  logic                    m_valid_q;
  logic [DRIVE_W-1:0]      m_drive_q;
  logic                    m_reached_q;

  logic [SENSOR_BITS-1:0]  err_q;
  logic [ELAPSED_W-1:0]    elapsed_q, el_sh_q;
  logic [PROD_W-1:0]       mop_q, prod_q;
  logic [ELAPSED_W-1:0]    rem_q;
  logic [DVD_W-1:0]        dvd_q;
  logic                    neg_q;
  logic                    reached_q;
  logic [ACC_W-1:0]        acc_q, op_q;
  logic [GAIN_W-1:0]       gsh_q;

  logic [SENSOR_BITS-1:0]  sample, err_in, diff_mag;
  logic [ELAPSED_W-1:0]    elapsed_in;
  logic                    start_in, accept, reached_in, out_free;
  logic [ERR_W-1:0]        last_eff, diff, diff_neg;
  logic [INTEG_W:0]        integ_sum;
  logic [INTEG_W-1:0]      integ_d;
  logic [ELAPSED_W+1:0]    trial;
  logic                    qbit;
  logic [ELAPSED_W-1:0]    rem_d;
  logic [QC_W-1:0]         q_ext, slope_mag, slope_neg;
  logic [SLOPE_W-1:0]      slope_d;
  logic [TERM_W-1:0]       term_sel;
  logic                    first;
  logic [ACC_W-1:0]        op_ld, op_cur, acc_d, acc_abs, acc_shr;
  logic [GAIN_W-1:0]       g_ld, g_cur;
  logic [DRIVE_W-2:0]      mag;
  logic [DRIVE_W-1:0]      drive_d;

  always_comb begin
    sample     = s_axis_tdata[SENSOR_BITS-1:0];
    elapsed_in = s_axis_tdata[SENSOR_BITS +: ELAPSED_W];
    start_in   = s_axis_tuser[0];
    accept     = s_axis_tvalid && (state_q == ST_IDLE);
    reached_in = sample >= target_q;
    err_in     = target_q - sample;
    last_eff   = start_in ? '0 : last_err_q;
    diff       = {1'b0, err_in} - last_eff;
    diff_neg   = -diff;
    diff_mag   = diff[ERR_W-1] ? diff_neg[SENSOR_BITS-1:0] : diff[SENSOR_BITS-1:0];
    out_free   = !m_valid_q || m_axis_tready;

    // saturating integral update
    integ_sum = {integ_q[INTEG_W-1], integ_q} + (INTEG_W+1)'(prod_q);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_d = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end

    // restoring divide step
    trial = {1'b0, rem_q, dvd_q[DVD_W-1]} - {2'b00, elapsed_q};
    qbit  = !trial[ELAPSED_W+1];
    rem_d = qbit ? trial[ELAPSED_W-1:0] : {rem_q[ELAPSED_W-2:0], dvd_q[DVD_W-1]};

    // slope from quotient magnitude, clamped to slope range
    q_ext = QC_W'(dvd_q);
    if (q_ext >= SLOPE_LIM) begin
      slope_mag = neg_q ? SLOPE_LIM : SLOPE_LIM - QC_W'(1);
    end else begin
      slope_mag = q_ext;
    end
    slope_neg = -slope_mag;
    slope_d   = neg_q ? slope_neg[SLOPE_W-1:0] : slope_mag[SLOPE_W-1:0];

    // shift-add multiply, one gain bit per cycle
    term_sel = cyc_q[CYC_W-1:GB_W];
    first    = cyc_q[GB_W-1:0] == '0;
    case (term_sel)
      TERM_P: begin
        op_ld = {{(ACC_W-SENSOR_BITS-SLOPE_FRAC){1'b0}}, err_q, {SLOPE_FRAC{1'b0}}};
        g_ld  = kp_q;
      end
      TERM_I: begin
        op_ld = {{(ACC_W-INTEG_W-SLOPE_FRAC){integ_q[INTEG_W-1]}}, integ_q,
                 {SLOPE_FRAC{1'b0}}};
        g_ld  = ki_q;
      end
      TERM_D: begin
        op_ld = {{(ACC_W-SLOPE_W){slope_q[SLOPE_W-1]}}, slope_q};
        g_ld  = kd_q;
      end
      default: begin
        op_ld = '0;
        g_ld  = '0;
      end
    endcase
    op_cur = first ? op_ld : op_q;
    g_cur  = first ? g_ld : gsh_q;
    acc_d  = acc_q + (g_cur[0] ? op_cur : '0);

    // truncate toward zero, saturate
    acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
    acc_shr = acc_abs >> SHIFT;
    mag     = (|acc_shr[ACC_W-1:DRIVE_W-1]) ? (DRIVE_W-1)'(DRIVE_LIMIT) : acc_shr[DRIVE_W-2:0];
    drive_d = acc_q[ACC_W-1] ? -{1'b0, mag} : {1'b0, mag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cyc_q       <= '0;
      target_q    <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      integ_q     <= '0;
      last_err_q  <= '0;
      slope_q     <= '0;
      m_valid_q   <= 1'b0;
      m_drive_q   <= '0;
      m_reached_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TARGET: target_q <= cfg_data_i[SENSOR_BITS-1:0];
          REG_KP:     kp_q     <= cfg_data_i;
          REG_KI:     ki_q     <= cfg_data_i;
          REG_KD:     kd_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tready && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (start_in) begin
              integ_q <= '0;
              slope_q <= '0;
            end
            if (reached_in) begin
              if (start_in) begin
                last_err_q <= '0;
              end
              state_q <= ST_FIN;
            end else begin
              last_err_q <= {1'b0, err_in};
              cyc_q      <= '0;
              state_q    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          cyc_q <= cyc_q + CYC_W'(1);
          if (cyc_q == CYC_W'(ELAPSED_W)) begin
            integ_q <= integ_d;
          end
          if (cyc_q == CYC_W'(DVD_W) && elapsed_q != '0) begin
            slope_q <= slope_d;
          end
          if (cyc_q == CYC_W'(MAC_CYC - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_valid_q   <= 1'b1;
            m_drive_q   <= drive_d;
            m_reached_q <= reached_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q     <= err_in;
      elapsed_q <= elapsed_in;
      el_sh_q   <= elapsed_in;
      mop_q     <= PROD_W'(err_in);
      prod_q    <= '0;
      rem_q     <= '0;
      dvd_q     <= {diff_mag, {SLOPE_FRAC{1'b0}}};
      neg_q     <= diff[ERR_W-1];
      acc_q     <= '0;
      reached_q <= reached_in;
    end else if (state_q == ST_RUN) begin
      if (cyc_q < CYC_W'(ELAPSED_W)) begin
        if (el_sh_q[0]) begin
          prod_q <= prod_q + mop_q;
        end
        mop_q   <= {mop_q[PROD_W-2:0], 1'b0};
        el_sh_q <= {1'b0, el_sh_q[ELAPSED_W-1:1]};
      end
      if (cyc_q < CYC_W'(DVD_W)) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[DVD_W-2:0], qbit};
      end
      acc_q <= acc_d;
      op_q  <= {op_cur[ACC_W-2:0], 1'b0};
      gsh_q <= {1'b0, g_cur[GAIN_W-1:1]};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_drive_q;
  assign m_axis_tuser  = m_reached_q;

endmodule

// File: src/lpd_check.sv
module lpd_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [lpd_pkg::DRIVE_W-1:0] m_axis_tdata,
  input logic [0:0]                  m_axis_tuser
);
  import lpd_pkg::*;

  localparam logic [DRIVE_W-1:0] DRIVE_NEG_MIN = ~DRIVE_W'(DRIVE_LIMIT);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_done_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("drive nonzero with target reached");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != DRIVE_NEG_MIN)
    else $error("drive outside saturation range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind lift_pid_drive lpd_check u_lpd_check (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata,
  .m_axis_tuser
);
